@@ rtl/a64dpi_pkg.sv @@
// Shared types, encodings and constants for the data-processing-immediate execute block.
// No dependencies; imported by every module under rtl.
package a64dpi_pkg;

   localparam int NUM_REGS = 31;

   typedef logic [4:0]  reg_idx_type;
   typedef logic [63:0] xword_type;
   typedef logic [31:0] instr_type;

   localparam reg_idx_type ZERO_REG = 5'd31;

   // instruction group, bits 25..23
   localparam logic [2:0] GRP_ADDSUB = 3'b010;
   localparam logic [2:0] GRP_MOVW   = 3'b101;

   // move-wide opc, bits 30..29
   localparam logic [1:0] OPC_MOVN = 2'b00;
   localparam logic [1:0] OPC_MOVR = 2'b01;
   localparam logic [1:0] OPC_MOVZ = 2'b10;
   localparam logic [1:0] OPC_MOVK = 2'b11;

   typedef struct packed {
      logic n;
      logic z;
      logic c;
      logic v;
   } flags_type;

   typedef struct packed {
      logic      ok;
      logic      set_flags;
      flags_type flags;
      xword_type value;
   } exec_result_type;

endpackage

@@ rtl/a64dpi_regfile.sv @@
// 31 x 64-bit general register file with two registered read ports and one write port.
// Depends on a64dpi_pkg; register 31 reads as zero, unwritten registers read as zero.
module a64dpi_regfile (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  rd_en,
   input  a64dpi_pkg::reg_idx_type rd_addr_a,
   input  a64dpi_pkg::reg_idx_type rd_addr_b,
   output a64dpi_pkg::xword_type rd_data_a,
   output a64dpi_pkg::xword_type rd_data_b,
   input  logic                  wr_en,
   input  a64dpi_pkg::reg_idx_type wr_addr,
   input  a64dpi_pkg::xword_type wr_data
);
   import a64dpi_pkg::*;

   xword_type            mem_ff [0:NUM_REGS-1];
   logic [NUM_REGS-1:0]  valid_ff;

   xword_type data_a_ff;
   xword_type data_b_ff;
   logic      hit_a_ff;
   logic      hit_b_ff;
   logic      byp_a_ff;
   logic      byp_b_ff;
   xword_type byp_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         data_a_ff   <= mem_ff[rd_addr_a];
         data_b_ff   <= mem_ff[rd_addr_b];
         byp_data_ff <= wr_data;
      end
   end

   // valid bits stand for the all-zero reset contents; a write landing on the
   // read address in the same cycle is forwarded
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         hit_a_ff <= 1'b0;
         hit_b_ff <= 1'b0;
         byp_a_ff <= 1'b0;
         byp_b_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            hit_a_ff <= (rd_addr_a != ZERO_REG) && valid_ff[rd_addr_a];
            hit_b_ff <= (rd_addr_b != ZERO_REG) && valid_ff[rd_addr_b];
            byp_a_ff <= wr_en && (wr_addr == rd_addr_a);
            byp_b_ff <= wr_en && (wr_addr == rd_addr_b);
         end
      end
   end

   assign rd_data_a = byp_a_ff ? byp_data_ff : (hit_a_ff ? data_a_ff : '0);
   assign rd_data_b = byp_b_ff ? byp_data_ff : (hit_b_ff ? data_b_ff : '0);

   a_no_zero_write: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> wr_addr != ZERO_REG)
      else $error("write to the zero register");

   a_fwd_only_real: assert property (@(posedge clock) disable iff (reset)
      rd_en && wr_en && (wr_addr == rd_addr_a) |=> byp_a_ff)
      else $error("write on the read address not forwarded");

endmodule

@@ rtl/a64dpi_exec.sv @@
// Combinational execute datapath: add/sub immediate with flags, and move wide.
// Depends on a64dpi_pkg for encodings and the result struct.
module a64dpi_exec (
   input  a64dpi_pkg::instr_type       instr,
   input  a64dpi_pkg::xword_type       op_n,
   input  a64dpi_pkg::xword_type       op_d,
   output a64dpi_pkg::exec_result_type result
);
   import a64dpi_pkg::*;

   logic        wide;
   logic [1:0]  opc;
   logic [2:0]  grp;
   logic [1:0]  hw;
   logic [5:0]  sh;
   xword_type   mask;
   xword_type   add_imm;
   xword_type   a;
   xword_type   bop;
   logic [64:0] sum;
   xword_type   r;
   logic        carry;
   logic        a_msb;
   logic        b_msb;
   logic        r_msb;
   xword_type   mv_imm;
   xword_type   keep;
   xword_type   mv;
   logic        mv_ok;

   always_comb begin
      wide = instr[31];
      opc  = instr[30:29];
      grp  = instr[25:23];
      hw   = instr[22:21];
      sh   = {hw, 4'b0000};
      mask = wide ? {64{1'b1}} : {32'h0000_0000, 32'hffff_ffff};

      add_imm = instr[22] ? {40'd0, instr[21:10], 12'd0} : {52'd0, instr[21:10]};
      a   = op_n & mask;
      bop = (opc[1] ? ~add_imm : add_imm) & mask;
      sum = {1'b0, a} + {1'b0, bop} + {64'd0, opc[1]};
      r   = sum[63:0] & mask;

      carry = wide ? sum[64] : sum[32];
      a_msb = wide ? a[63]   : a[31];
      b_msb = wide ? bop[63] : bop[31];
      r_msb = wide ? r[63]   : r[31];

      mv_imm = {48'd0, instr[20:5]} << sh;
      keep   = ~({48'd0, 16'hffff} << sh);
      case (opc)
         OPC_MOVN: mv = ~mv_imm;
         OPC_MOVZ: mv = mv_imm;
         OPC_MOVK: mv = mv_imm | (op_d & keep);
         default:  mv = '0;
      endcase
      mv    = mv & mask;
      mv_ok = (opc != OPC_MOVR) && (wide || !hw[1]);

      result = '0;
      unique case (grp)
         GRP_ADDSUB: begin
            result.ok        = 1'b1;
            result.value     = r;
            result.set_flags = opc[0];
            result.flags.n   = r_msb;
            result.flags.z   = (r == '0);
            result.flags.c   = carry;
            result.flags.v   = (a_msb == b_msb) && (r_msb != a_msb);
         end
         GRP_MOVW: begin
            result.ok    = mv_ok;
            result.value = mv_ok ? mv : '0;
         end
         default: begin
            result = '0;
         end
      endcase
   end

endmodule

@@ rtl/aarch64_dp_immediate_exec.sv @@
// Operands are read at the accepting edge, executed in stage 1 and registered on advance;
// a stalled result holds the pipe. Throughput: one request per cycle unless a result stalls;
// a request is accepted while a result still waits if stage 1 is empty.
// Synchronous active-high reset clears registers to zero, flags, PC and both pipe stages.
// Register state lives in a64dpi_regfile; valid bits give the zero reset contents at once.
// Depends on a64dpi_pkg, a64dpi_regfile and a64dpi_exec.
module aarch64_dp_immediate_exec (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  a64dpi_pkg::instr_type   req_instruction,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output a64dpi_pkg::reg_idx_type rsp_dest_index,
   output logic                    rsp_dest_written,
   output a64dpi_pkg::xword_type   rsp_dest_value,
   output logic                    rsp_flag_negative,
   output logic                    rsp_flag_zero,
   output logic                    rsp_flag_carry,
   output logic                    rsp_flag_overflow,
   output a64dpi_pkg::xword_type   rsp_next_pc
);
   import a64dpi_pkg::*;

   // stage 1: instruction held while its operands come out of the register file
   logic      s1_valid_ff;
   instr_type s1_instr_ff;

   // architectural state outside the register file
   flags_type flags_ff;
   flags_type flags_in;
   xword_type pc_ff;
   xword_type pc_in;

   // result register
   logic        rsp_valid_ff;
   reg_idx_type rsp_dest_index_ff;
   logic        rsp_dest_written_ff;
   xword_type   rsp_dest_value_ff;
   flags_type   rsp_flags_ff;
   xword_type   rsp_next_pc_ff;

   logic            accept;
   logic            out_free;
   logic            s1_adv;
   logic            wr_en;
   reg_idx_type     s1_rd;
   xword_type       op_n;
   xword_type       op_d;
   exec_result_type res;

   // advance stage 1 whenever the result register is empty or being drained
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_adv    = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || s1_adv;
   assign accept    = req_valid && req_ready;

   assign s1_rd = s1_instr_ff[4:0];
   assign wr_en = s1_adv && res.ok && (s1_rd != ZERO_REG);

   // Rn on port A, Rd on port B (old value for MOVK); a commit in the same
   // cycle as the read is forwarded inside the register file
   a64dpi_regfile u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (accept),
      .rd_addr_a (req_instruction[9:5]),
      .rd_addr_b (req_instruction[4:0]),
      .rd_data_a (op_n),
      .rd_data_b (op_d),
      .wr_en     (wr_en),
      .wr_addr   (s1_rd),
      .wr_data   (res.value)
   );

   a64dpi_exec u_exec (
      .instr  (s1_instr_ff),
      .op_n   (op_n),
      .op_d   (op_d),
      .result (res)
   );

   // flags change only on ADDS/SUBS; PC steps by four for every request
   assign flags_in = (res.ok && res.set_flags) ? res.flags : flags_ff;
   assign pc_in    = pc_ff + 64'd4;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         flags_ff     <= '0;
         pc_ff        <= '0;
      end else begin
         if (req_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (s1_adv) begin
            rsp_valid_ff <= 1'b1;
            flags_ff     <= flags_in;
            pc_ff        <= pc_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload: hold while stalled, load on advance
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_instr_ff <= req_instruction;
      end
      if (s1_adv) begin
         rsp_dest_index_ff   <= s1_rd;
         rsp_dest_written_ff <= wr_en;
         rsp_dest_value_ff   <= res.value;
         rsp_flags_ff        <= flags_in;
         rsp_next_pc_ff      <= pc_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_dest_index    = rsp_dest_index_ff;
   assign rsp_dest_written  = rsp_dest_written_ff;
   assign rsp_dest_value    = rsp_dest_value_ff;
   assign rsp_flag_negative = rsp_flags_ff.n;
   assign rsp_flag_zero     = rsp_flags_ff.z;
   assign rsp_flag_carry    = rsp_flags_ff.c;
   assign rsp_flag_overflow = rsp_flags_ff.v;
   assign rsp_next_pc       = rsp_next_pc_ff;

   a_adv_shows_result: assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> rsp_valid)
      else $error("advanced request did not reach the result register");

   a_pc_steps: assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> pc_ff == $past(pc_ff) + 64'd4)
      else $error("program counter did not step by four");

   a_pc_holds: assert property (@(posedge clock) disable iff (reset)
      !s1_adv |=> $stable(pc_ff) && $stable(flags_ff))
      else $error("state changed without a committed request");

   a_written_not_zr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_dest_written |-> rsp_dest_index != ZERO_REG)
      else $error("zero register reported as written");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for aarch64_dp_immediate_exec: add/sub and move-wide immediates.
// Depends on a64dpi_pkg and the RTL top; shadows the register file, flags and PC itself.
module tb;
   import a64dpi_pkg::*;

   localparam int unsigned RANDOM_ITEMS = 1350;
   localparam int unsigned STALL_LIMIT  = 2000;  // cycles with no handshake at all
   localparam int unsigned TAIL_CYCLES  = 10;    // two-stage pipe, plus margin

   // bits 28..26 of the data-processing-immediate class
   localparam logic [2:0] CLASS_DPI = 3'b100;

   // add/sub opc, bits 30..29
   localparam logic [1:0] OPC_ADD  = 2'b00;
   localparam logic [1:0] OPC_ADDS = 2'b01;
   localparam logic [1:0] OPC_SUB  = 2'b10;
   localparam logic [1:0] OPC_SUBS = 2'b11;

   typedef struct {
      reg_idx_type rd;
      logic        written;
      xword_type   value;
      flags_type   flags;
      xword_type   pc;
   } retire_rec_type;

   // Architectural shadow of the block: executes every accepted request in order
   // and holds the outcomes still to be retired by the block.
   class dp_imm_shadow_type;
      xword_type      gpr [NUM_REGS];
      flags_type      nzcv;
      xword_type      pc;
      retire_rec_type in_flight [$];
      int unsigned    mismatches;

      function new();
         foreach (gpr[i]) gpr[i] = '0;
         nzcv       = '0;
         pc         = '0;
         mismatches = 0;
      endfunction

      function xword_type read_gpr(reg_idx_type idx);
         return (idx == ZERO_REG) ? '0 : gpr[idx];
      endfunction

      function int unsigned pending();
         return in_flight.size();
      endfunction

      function void issue(instr_type ins);
         logic           wide, sub, setf, ok, n, c, v;
         logic [1:0]     opc, hw;
         logic [2:0]     grp;
         reg_idx_type    rd, rn;
         xword_type      a, b, r, imm;
         logic [64:0]    sum64;
         logic [32:0]    sum32;
         int unsigned    sh;
         retire_rec_type rec;
         wide = ins[31];
         opc  = ins[30:29];
         grp  = ins[25:23];
         hw   = ins[22:21];
         rn   = ins[9:5];
         rd   = ins[4:0];
         ok   = 1'b0;
         r    = '0;
         if (grp == GRP_ADDSUB) begin
            sub  = (opc == OPC_SUB)  || (opc == OPC_SUBS);
            setf = (opc == OPC_ADDS) || (opc == OPC_SUBS);
            a = read_gpr(rn);
            b = ins[22] ? (xword_type'(ins[21:10]) << 12) : xword_type'(ins[21:10]);
            if (wide) begin
               // subtract as a + ~b + 1, so carry out is "no borrow"
               sum64 = sub ? {1'b0, a} + {1'b0, ~b} + 65'd1 : {1'b0, a} + {1'b0, b};
               r = sum64[63:0];
               c = sum64[64];
               n = r[63];
               v = sub ? ((a[63] ^ b[63]) & (a[63] ^ r[63]))
                       : (~(a[63] ^ b[63]) & (a[63] ^ r[63]));
            end else begin
               sum32 = sub ? {1'b0, a[31:0]} + {1'b0, ~b[31:0]} + 33'd1
                           : {1'b0, a[31:0]} + {1'b0, b[31:0]};
               r = {32'h0, sum32[31:0]};
               c = sum32[32];
               n = r[31];
               v = sub ? ((a[31] ^ b[31]) & (a[31] ^ r[31]))
                       : (~(a[31] ^ b[31]) & (a[31] ^ r[31]));
            end
            if (setf) nzcv = flags_type'({n, (r == '0), c, v});
            ok = 1'b1;
         end else if (grp == GRP_MOVW && opc != OPC_MOVR && (wide || hw < 2'd2)) begin
            sh  = 16 * hw;
            imm = xword_type'(ins[20:5]) << sh;
            case (opc)
               OPC_MOVN: r = ~imm;
               OPC_MOVZ: r = imm;
               default:  r = imm | (read_gpr(rd) & ~(64'hffff << sh));
            endcase
            if (!wide) r[63:32] = '0;
            ok = 1'b1;
         end
         if (ok && rd != ZERO_REG) gpr[rd] = r;
         pc          = pc + 64'd4;
         rec.rd      = rd;
         rec.written = ok && (rd != ZERO_REG);
         rec.value   = ok ? r : '0;
         rec.flags   = nzcv;
         rec.pc      = pc;
         in_flight.push_back(rec);
      endfunction

      function void flag_mismatch(string field, xword_type want, xword_type got);
         mismatches++;
         $display("%0t: %s mismatch: expected %h, got %h", $time, field, want, got);
      endfunction

      function void retire(retire_rec_type got);
         retire_rec_type want;
         if (in_flight.size() == 0) begin
            mismatches++;
            $display("%0t: result with none outstanding: expected nothing, got rd %0d value %h",
                     $time, got.rd, got.value);
            return;
         end
         want = in_flight.pop_front();
         if (got.rd !== want.rd)
            flag_mismatch("dest_index", xword_type'(want.rd), xword_type'(got.rd));
         if (got.written !== want.written)
            flag_mismatch("dest_written", xword_type'(want.written), xword_type'(got.written));
         if (got.value !== want.value)     flag_mismatch("dest_value", want.value, got.value);
         if (got.flags.n !== want.flags.n)
            flag_mismatch("flag_negative", xword_type'(want.flags.n), xword_type'(got.flags.n));
         if (got.flags.z !== want.flags.z)
            flag_mismatch("flag_zero", xword_type'(want.flags.z), xword_type'(got.flags.z));
         if (got.flags.c !== want.flags.c)
            flag_mismatch("flag_carry", xword_type'(want.flags.c), xword_type'(got.flags.c));
         if (got.flags.v !== want.flags.v)
            flag_mismatch("flag_overflow", xword_type'(want.flags.v), xword_type'(got.flags.v));
         if (got.pc !== want.pc)           flag_mismatch("next_pc", want.pc, got.pc);
      endfunction
   endclass

   typedef enum logic [1:0] {RX_STREAM, RX_COIN, RX_QUARTER, RX_BURSTY} rx_mode_type;

   logic        clock           = 1'b0;
   logic        reset           = 1'b1;
   logic        req_valid       = 1'b0;
   logic        req_ready;
   instr_type   req_instruction = '0;
   logic        rsp_valid;
   logic        rsp_ready       = 1'b0;
   reg_idx_type rsp_dest_index;
   logic        rsp_dest_written;
   xword_type   rsp_dest_value;
   logic        rsp_flag_negative;
   logic        rsp_flag_zero;
   logic        rsp_flag_carry;
   logic        rsp_flag_overflow;
   xword_type   rsp_next_pc;

   dp_imm_shadow_type shadow = new();

   int unsigned sent         = 0;
   int unsigned burst_left   = 0;
   int unsigned quiet_cycles = 0;
   int unsigned rx_cycle     = 0;
   rx_mode_type rx_mode      = RX_STREAM;

   aarch64_dp_immediate_exec dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_instruction   (req_instruction),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_dest_index    (rsp_dest_index),
      .rsp_dest_written  (rsp_dest_written),
      .rsp_dest_value    (rsp_dest_value),
      .rsp_flag_negative (rsp_flag_negative),
      .rsp_flag_zero     (rsp_flag_zero),
      .rsp_flag_carry    (rsp_flag_carry),
      .rsp_flag_overflow (rsp_flag_overflow),
      .rsp_next_pc       (rsp_next_pc)
   );

   always #5 clock = ~clock;

   // Build instruction words in the architectural layout.
   function automatic instr_type enc_addsub(logic sf, logic [1:0] opc, logic sh,
                                            logic [11:0] imm12, reg_idx_type rn,
                                            reg_idx_type rd);
      return {sf, opc, CLASS_DPI, GRP_ADDSUB, sh, imm12, rn, rd};
   endfunction

   function automatic instr_type enc_movw(logic sf, logic [1:0] opc, logic [1:0] hw,
                                          logic [15:0] imm16, reg_idx_type rd);
      return {sf, opc, CLASS_DPI, GRP_MOVW, hw, imm16, rd};
   endfunction

   // Favour the boundary values that flip carry, overflow and sign.
   function automatic logic [15:0] pick_imm16();
      case ($urandom_range(0, 7))
         0:       return 16'h0000;
         1:       return 16'hffff;
         2:       return 16'h8000;
         3:       return 16'h7fff;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [11:0] pick_imm12();
      case ($urandom_range(0, 5))
         0:       return 12'h000;
         1:       return 12'h001;
         2:       return 12'hfff;
         default: return 12'($urandom);
      endcase
   endfunction

   // Drive one request from the falling edge and hold it until the block takes it.
   // Requests go out in bursts; a fresh burst may open with a few idle cycles.
   task automatic send_request(instr_type ins);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         repeat (gap) begin
            @(negedge clock);
            req_valid <= 1'b0;
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid       <= 1'b1;
      req_instruction <= ins;
      do @(posedge clock); while (!req_ready);
      sent++;
   endtask

   // Result back-pressure: switch at random between four ready patterns so that stalls
   // land on every pipe phase, with long stretches of full flow too.
   always @(negedge clock) begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle % 97 == 0) rx_mode <= rx_mode_type'($urandom_range(0, 3));
      case (rx_mode)
         RX_STREAM:  rsp_ready <= 1'b1;
         RX_COIN:    rsp_ready <= 1'($urandom_range(0, 1));
         RX_QUARTER: rsp_ready <= (rx_cycle % 4 == 3);
         default:    rsp_ready <= (rx_cycle % 16 >= 11);
      endcase
   end

   // Sample both channels at the rising edge; the shadow executes each accepted
   // request and every accepted result is checked against the oldest outcome.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) shadow.issue(req_instruction);
         if (rsp_valid && rsp_ready)
            shadow.retire('{rsp_dest_index, rsp_dest_written, rsp_dest_value,
                            flags_type'({rsp_flag_negative, rsp_flag_zero,
                                         rsp_flag_carry, rsp_flag_overflow}),
                            rsp_next_pc});
         // watchdog: drop the run if the block goes quiet for too long
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   initial begin
      int unsigned target;
      int unsigned pick;
      reg_idx_type base, rd2;
      logic        sf;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Opening sequence: move-wide extremes, flag corner cases, zero register as
      // source and destination, and the encodings that must write nothing.
      send_request(enc_movw(1'b1, OPC_MOVZ, 2'd3, 16'hffff, 5'd0));
      send_request(enc_movw(1'b1, OPC_MOVK, 2'd0, 16'h1234, 5'd0));
      send_request(enc_movw(1'b1, OPC_MOVN, 2'd0, 16'h0000, 5'd1));
      send_request(enc_movw(1'b0, OPC_MOVN, 2'd1, 16'h0000, 5'd2));
      send_request(enc_movw(1'b0, OPC_MOVZ, 2'd2, 16'hffff, 5'd3));  // 32-bit, hw too big
      send_request(enc_movw(1'b0, OPC_MOVK, 2'd1, 16'habcd, 5'd0));  // clears upper half
      send_request(enc_addsub(1'b1, OPC_ADDS, 1'b0, 12'd1, 5'd1, 5'd4));       // Z and C
      send_request(enc_addsub(1'b1, OPC_SUBS, 1'b0, 12'd1, ZERO_REG, 5'd5));   // borrow
      send_request(enc_addsub(1'b0, OPC_ADDS, 1'b1, 12'hfff, 5'd1, 5'd6));
      send_request(enc_movw(1'b1, OPC_MOVN, 2'd3, 16'h8000, 5'd7));  // max positive
      send_request(enc_addsub(1'b1, OPC_ADDS, 1'b0, 12'd1, 5'd7, 5'd8));       // add overflow
      send_request(enc_movw(1'b1, OPC_MOVZ, 2'd3, 16'h8000, 5'd10)); // min negative
      send_request(enc_addsub(1'b1, OPC_SUBS, 1'b0, 12'd1, 5'd10, 5'd11));     // sub overflow
      send_request(enc_movw(1'b0, OPC_MOVN, 2'd1, 16'h8000, 5'd12));
      send_request(enc_addsub(1'b0, OPC_ADDS, 1'b0, 12'd1, 5'd12, 5'd13));     // 32-bit overflow
      send_request(enc_addsub(1'b1, OPC_ADDS, 1'b0, 12'd1, 5'd1, ZERO_REG));   // flags only
      send_request(enc_movw(1'b1, OPC_MOVK, 2'd2, 16'h5a5a, ZERO_REG));        // old value zero
      send_request(enc_addsub(1'b1, OPC_ADD, 1'b0, 12'hfff, 5'd0, 5'd14));
      send_request(enc_addsub(1'b1, OPC_SUB, 1'b1, 12'hfff, 5'd0, 5'd15));
      send_request(enc_movw(1'b1, OPC_MOVR, 2'd0, 16'hffff, 5'd16)); // reserved opc
      send_request(32'hffff_ffff);
      send_request(32'h0000_0000);
      send_request(enc_addsub(1'b0, OPC_SUBS, 1'b0, 12'd0, ZERO_REG, 5'd16));  // Z with C
      send_request(enc_movw(1'b1, OPC_MOVK, 2'd3, 16'hffff, 5'd30));

      // Random part, mostly well-formed chains: build a value with MOVZ/MOVN and
      // some MOVKs, then run add/sub on it. The rest: lone instructions and noise.
      target = sent + RANDOM_ITEMS;
      while (sent < target) begin
         pick = $urandom_range(0, 19);
         if (pick < 10) begin
            base = reg_idx_type'($urandom_range(0, 30));
            sf   = 1'($urandom_range(0, 1));
            send_request(enc_movw(sf, $urandom_range(0, 1) ? OPC_MOVZ : OPC_MOVN,
                                  sf ? 2'($urandom_range(0, 3)) : 2'($urandom_range(0, 1)),
                                  pick_imm16(), base));
            repeat ($urandom_range(0, 3))
               send_request(enc_movw(sf, OPC_MOVK,
                                     sf ? 2'($urandom_range(0, 3)) : 2'($urandom_range(0, 1)),
                                     pick_imm16(), base));
            repeat ($urandom_range(1, 3)) begin
               case ($urandom_range(0, 7))
                  0:       rd2 = ZERO_REG;
                  1:       rd2 = base;
                  default: rd2 = reg_idx_type'($urandom_range(0, 30));
               endcase
               send_request(enc_addsub($urandom_range(0, 3) != 0 ? sf : ~sf,
                                       2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                                       pick_imm12(), base, rd2));
            end
         end else if (pick < 13) begin
            send_request(enc_addsub(1'($urandom), 2'($urandom), 1'($urandom), pick_imm12(),
                                    reg_idx_type'($urandom), reg_idx_type'($urandom)));
         end else if (pick < 16) begin
            send_request(enc_movw(1'($urandom), 2'($urandom), 2'($urandom), pick_imm16(),
                                  reg_idx_type'($urandom)));
         end else begin
            send_request(instr_type'($urandom));
         end
      end

      // Drain: release valid, wait for every outcome to retire, then let the pipe
      // settle so that any stray result is caught.
      @(negedge clock);
      req_valid <= 1'b0;
      while (shadow.pending() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (shadow.mismatches == 0 && shadow.pending() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
